// ===== rtl/core/pthc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_pkg
// Shared types, constants and arithmetic helpers for the pressure, humidity
// and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package pthc_pkg;

  localparam logic [2:0] REG_TEMP   = 3'd0;
  localparam logic [2:0] REG_PLOW   = 3'd1;
  localparam logic [2:0] REG_PHIGH  = 3'd2;
  localparam logic [2:0] REG_PNINE  = 3'd3;
  localparam logic [2:0] REG_HUM    = 3'd4;

  localparam int TEMP_LAT  = 5;
  localparam int DIV_LAT   = 32;
  localparam int PRESS_LAT = 7 + DIV_LAT + 3;
  localparam int HUM_LAT   = 10;
  localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

  localparam logic [16:0] HUM_MAX = 17'd102400;

  typedef struct packed {
    logic        valid;
    logic [31:0] tf;
    logic [31:0] temp;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
  } tf_bus_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] full;
    full = {32'd0, a} * {32'd0, b};
    return full[31:0];
  endfunction

endpackage

// ===== rtl/core/pthc_temp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_temp
// Temperature stages: fine temperature and centidegree result.
// ----------------------------------------------------------------------------
module pthc_temp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [19:0]          in_adc_t,
  input  logic [19:0]          in_adc_p,
  input  logic [15:0]          in_adc_h,
  input  logic [47:0]          coef_t,
  output pthc_pkg::tf_bus_t    out_bus
);

  localparam int TEMP_LAT_W = pthc_pkg::TEMP_LAT;
  logic [31:0] t1, t2, t3;
  logic [TEMP_LAT_W-1:0] vld_r;
  logic [19:0] ap_r [TEMP_LAT_W];
  logic [15:0] ah_r [TEMP_LAT_W];
  logic [31:0] a0_r, d_r, am_r, dd_r, a_r, b0_r, tf_r, tf2_r, temp_r;
  logic [31:0] a0_nxt, d_nxt, temp_nxt;

  assign t1 = {16'd0, coef_t[15:0]};
  assign t2 = pthc_pkg::sx16(coef_t[31:16]);
  assign t3 = pthc_pkg::sx16(coef_t[47:32]);

  assign a0_nxt   = {15'd0, in_adc_t[19:3]} - (t1 << 1);
  assign d_nxt    = {16'd0, in_adc_t[19:4]} - t1;
  assign temp_nxt = pthc_pkg::asr(pthc_pkg::mul32(tf_r, 32'd5) + 32'd128, 5'd8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TEMP_LAT_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ap_r[0] <= in_adc_p;
    ah_r[0] <= in_adc_h;
    for (int i = 1; i < TEMP_LAT_W; i++) begin
      ap_r[i] <= ap_r[i-1];
      ah_r[i] <= ah_r[i-1];
    end
    a0_r   <= a0_nxt;
    d_r    <= d_nxt;
    am_r   <= pthc_pkg::mul32(a0_r, t2);
    dd_r   <= pthc_pkg::mul32(d_r, d_r);
    a_r    <= pthc_pkg::asr(am_r, 5'd11);
    b0_r   <= pthc_pkg::mul32(pthc_pkg::asr(dd_r, 5'd12), t3);
    tf_r   <= a_r + pthc_pkg::asr(b0_r, 5'd14);
    tf2_r  <= tf_r;
    temp_r <= temp_nxt;
  end

  assign out_bus.valid = vld_r[TEMP_LAT_W-1];
  assign out_bus.tf    = tf2_r;
  assign out_bus.temp  = temp_r;
  assign out_bus.adc_p = ap_r[TEMP_LAT_W-1];
  assign out_bus.adc_h = ah_r[TEMP_LAT_W-1];

endmodule

// ===== rtl/core/pthc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_div
// Pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pthc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_num,
  input  logic [31:0] in_den,
  input  logic [1:0]  in_tag,
  output logic        out_valid,
  output logic [31:0] out_quo,
  output logic [1:0]  out_tag
);

  localparam int N = pthc_pkg::DIV_LAT;

  logic [N-1:0] vld_r;
  logic [31:0]  rem_r [N];
  logic [31:0]  num_r [N];
  logic [31:0]  den_r [N];
  logic [1:0]   tag_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] rem_in, num_in, den_in;
    logic [1:0]  tag_in;
    logic [32:0] trial;
    logic [32:0] diff;
    if (k == 0) begin : g_first
      assign rem_in = 32'd0;
      assign num_in = in_num;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end
    assign trial = {rem_in, num_in[31]};
    assign diff  = trial - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (!diff[32]) begin
        rem_r[k] <= diff[31:0];
        num_r[k] <= {num_in[30:0], 1'b1};
      end else begin
        rem_r[k] <= trial[31:0];
        num_r[k] <= {num_in[30:0], 1'b0};
      end
      den_r[k] <= den_in;
      tag_r[k] <= tag_in;
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quo   = num_r[N-1];
  assign out_tag   = tag_r[N-1];

endmodule

// ===== rtl/core/pthc_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_press
// Pressure stages: offset and scale terms, divider, final correction.
// ----------------------------------------------------------------------------
module pthc_press (
  input  logic               clk,
  input  logic               rst_n,
  input  pthc_pkg::tf_bus_t  in_bus,
  input  logic [63:0]        coef_lo,
  input  logic [63:0]        coef_hi,
  input  logic [15:0]        coef_p9,
  output logic               out_valid,
  output logic [31:0]        out_pascal,
  output logic               out_invalid
);

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [6:0]  vld_r;
  logic [19:0] ap_r [6];
  logic [31:0] v1_r, q_r, qq_r, v1p5_r, p2v1_r, x6_r, x3_r, p5b_r, p2b_r;
  logic [31:0] v2_r, v1b_r, v2c_r, m_r, v1c_r, pn_r, v1d_r, pm_r;
  logic [31:0] v2_nxt, v1b_nxt, div_num, div_quo;
  logic        dbl, div_valid;
  logic [1:0]  div_tag;
  logic [2:0]  qv_r;
  logic [31:0] p_r, ppm_r, pr8_r, pb_r, pr8b_r, vm_r, pout_r;
  logic [1:0]  tq_r, tq2_r, tq3_r;
  logic [31:0] pq_nxt;

  assign p1 = {16'd0, coef_lo[15:0]};
  assign p2 = pthc_pkg::sx16(coef_lo[31:16]);
  assign p3 = pthc_pkg::sx16(coef_lo[47:32]);
  assign p4 = pthc_pkg::sx16(coef_lo[63:48]);
  assign p5 = pthc_pkg::sx16(coef_hi[15:0]);
  assign p6 = pthc_pkg::sx16(coef_hi[31:16]);
  assign p7 = pthc_pkg::sx16(coef_hi[47:32]);
  assign p8 = pthc_pkg::sx16(coef_hi[63:48]);
  assign p9 = pthc_pkg::sx16(coef_p9);

  assign v2_nxt  = pthc_pkg::asr(x6_r + (p5b_r << 1), 5'd2) + (p4 << 16);
  assign v1b_nxt = pthc_pkg::asr(pthc_pkg::asr(x3_r, 5'd3) + pthc_pkg::asr(p2b_r, 5'd1),
                                 5'd18);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_bus.valid};
      qv_r  <= {qv_r[1:0], div_valid};
    end
  end

  always_ff @(posedge clk) begin
    ap_r[0] <= in_bus.adc_p;
    for (int i = 1; i < 6; i++) begin
      ap_r[i] <= ap_r[i-1];
    end
    // stage 1
    v1_r   <= pthc_pkg::asr(in_bus.tf, 5'd1) - 32'd64000;
    q_r    <= pthc_pkg::asr(pthc_pkg::asr(in_bus.tf, 5'd1) - 32'd64000, 5'd2);
    // stage 2
    qq_r   <= pthc_pkg::mul32(q_r, q_r);
    v1p5_r <= pthc_pkg::mul32(v1_r, p5);
    p2v1_r <= pthc_pkg::mul32(p2, v1_r);
    // stage 3
    x6_r   <= pthc_pkg::mul32(pthc_pkg::asr(qq_r, 5'd11), p6);
    x3_r   <= pthc_pkg::mul32(p3, pthc_pkg::asr(qq_r, 5'd13));
    p5b_r  <= v1p5_r;
    p2b_r  <= p2v1_r;
    // stage 4
    v2_r   <= v2_nxt;
    v1b_r  <= v1b_nxt;
    // stage 5
    m_r    <= pthc_pkg::mul32(32'd32768 + v1b_r, p1);
    v2c_r  <= v2_r;
    // stage 6
    v1c_r  <= pthc_pkg::asr(m_r, 5'd15);
    pn_r   <= (32'd1048576 - {12'd0, ap_r[4]}) - pthc_pkg::asr(v2c_r, 5'd12);
    // stage 7
    pm_r   <= pthc_pkg::mul32(pn_r, 32'd3125);
    v1d_r  <= v1c_r;
  end

  assign dbl     = pm_r[31];
  assign div_num = dbl ? pm_r : {pm_r[30:0], 1'b0};

  pthc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[6]),
    .in_num    (div_num),
    .in_den    (v1d_r),
    .in_tag    ({v1d_r == 32'd0, dbl}),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_tag   (div_tag)
  );

  assign pq_nxt = div_tag[0] ? {div_quo[30:0], 1'b0} : div_quo;

  always_ff @(posedge clk) begin
    p_r    <= pq_nxt;
    ppm_r  <= pthc_pkg::mul32({3'd0, pq_nxt[31:3]}, {3'd0, pq_nxt[31:3]});
    pr8_r  <= pthc_pkg::mul32({2'd0, pq_nxt[31:2]}, p8);
    tq_r   <= div_tag;
    vm_r   <= pthc_pkg::mul32(p9, {13'd0, ppm_r[31:13]});
    pb_r   <= p_r;
    pr8b_r <= pr8_r;
    tq2_r  <= tq_r;
    pout_r <= tq2_r[1] ? 32'd0 :
              pb_r + pthc_pkg::asr(pthc_pkg::asr(vm_r, 5'd12) +
                                   pthc_pkg::asr(pr8b_r, 5'd13) + p7, 5'd4);
    tq3_r  <= tq2_r;
  end

  assign out_valid   = qv_r[2];
  assign out_pascal  = pout_r;
  assign out_invalid = tq3_r[1];

endmodule

// ===== rtl/core/pthc_hum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pthc_hum
// Humidity stages with clamp to the full-scale range.
// ----------------------------------------------------------------------------
module pthc_hum (
  input  logic        clk,
  input  logic [31:0] in_tf,
  input  logic [15:0] in_adc_h,
  input  logic [63:0] coef_h,
  output logic [16:0] out_hum
);

  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [31:0] x_r, m5_r, m6_r, m3_r, part1_r, u_r, w_r, uw_r, ym_r, part2_r;
  logic [31:0] p1b_r, p1c_r, p1d_r, hx_r, ss_r, hx2_r, t_r, hx3_r;
  logic [15:0] ah_r, ah2_r;
  logic [31:0] hx_nxt, fin;
  logic [16:0] hum_r;

  assign h1 = {24'd0, coef_h[7:0]};
  assign h2 = pthc_pkg::sx16(coef_h[23:8]);
  assign h3 = {24'd0, coef_h[31:24]};
  assign h4 = pthc_pkg::sx12(coef_h[43:32]);
  assign h5 = pthc_pkg::sx12(coef_h[55:44]);
  assign h6 = pthc_pkg::sx8(coef_h[63:56]);

  assign hx_nxt = pthc_pkg::mul32(p1d_r, part2_r);
  assign fin    = hx3_r - pthc_pkg::asr(t_r, 5'd4);

  always_ff @(posedge clk) begin
    x_r     <= in_tf - 32'd76800;
    ah_r    <= in_adc_h;
    m5_r    <= pthc_pkg::mul32(h5, x_r);
    m6_r    <= pthc_pkg::mul32(x_r, h6);
    m3_r    <= pthc_pkg::mul32(x_r, h3);
    ah2_r   <= ah_r;
    part1_r <= pthc_pkg::asr((({2'd0, ah2_r, 14'd0}) - (h4 << 20) - m5_r) + 32'd16384,
                             5'd15);
    u_r     <= pthc_pkg::asr(m6_r, 5'd10);
    w_r     <= pthc_pkg::asr(m3_r, 5'd11) + 32'd32768;
    uw_r    <= pthc_pkg::mul32(u_r, w_r);
    p1b_r   <= part1_r;
    ym_r    <= pthc_pkg::mul32(pthc_pkg::asr(uw_r, 5'd10) + 32'd2097152, h2);
    p1c_r   <= p1b_r;
    part2_r <= pthc_pkg::asr(ym_r + 32'd8192, 5'd14);
    p1d_r   <= p1c_r;
    hx_r    <= hx_nxt;
    ss_r    <= pthc_pkg::mul32(pthc_pkg::asr(hx_r, 5'd15), pthc_pkg::asr(hx_r, 5'd15));
    hx2_r   <= hx_r;
    t_r     <= pthc_pkg::mul32(pthc_pkg::asr(ss_r, 5'd7), h1);
    hx3_r   <= hx2_r;
    if (fin[31]) begin
      hum_r <= 17'd0;
    end else if (fin > 32'd419430400) begin
      hum_r <= pthc_pkg::HUM_MAX;
    end else begin
      hum_r <= fin[28:12];
    end
  end

  assign out_hum = hum_r;

endmodule

// ===== rtl/core/pth_sensor_compensation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation_top
// Fully pipelined integer compensation of one raw reading per cycle.
//
//  channel | ports                        | handshake
//  input   | in_raw_*                     | start high, busy low
//  result  | out_*                        | out_valid strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_data  | write on cfg_we
//
// one reading enters every cycle; its result leaves the pipeline with out_valid
// latency is set by the 32-stage pressure divider plus the multiply stages
// synchronous active-low reset clears coefficients and the valid pipeline
// busy is held low; the receiver takes every strobe, so nothing stalls
// ----------------------------------------------------------------------------
module pth_sensor_compensation_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_pressure,
  input  logic [19:0] in_raw_temperature,
  input  logic [15:0] in_raw_humidity,
  output logic        out_valid,
  output logic [31:0] out_temperature_centideg,
  output logic [31:0] out_pressure_pascal,
  output logic        out_pressure_invalid,
  output logic [16:0] out_humidity_q22_10,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PL = pthc_pkg::PRESS_LAT;
  localparam int HD = pthc_pkg::PRESS_LAT - pthc_pkg::HUM_LAT;

  logic [47:0] tc_r;
  logic [63:0] pl_r, ph_r, hc_r;
  logic [15:0] p9_r;
  pthc_pkg::tf_bus_t tbus;
  logic        p_valid, p_inv;
  logic [31:0] p_pa;
  logic [16:0] hum;
  logic [31:0] tdl_r [PL];
  logic [16:0] hdl_r [HD];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0;
      pl_r <= '0;
      ph_r <= '0;
      p9_r <= '0;
      hc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pthc_pkg::REG_TEMP:  tc_r <= cfg_data[47:0];
        pthc_pkg::REG_PLOW:  pl_r <= cfg_data;
        pthc_pkg::REG_PHIGH: ph_r <= cfg_data;
        pthc_pkg::REG_PNINE: p9_r <= cfg_data[15:0];
        pthc_pkg::REG_HUM:   hc_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pthc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_adc_t (in_raw_temperature),
    .in_adc_p (in_raw_pressure),
    .in_adc_h (in_raw_humidity),
    .coef_t   (tc_r),
    .out_bus  (tbus)
  );

  pthc_press u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (tbus),
    .coef_lo     (pl_r),
    .coef_hi     (ph_r),
    .coef_p9     (p9_r),
    .out_valid   (p_valid),
    .out_pascal  (p_pa),
    .out_invalid (p_inv)
  );

  pthc_hum u_hum (
    .clk      (clk),
    .in_tf    (tbus.tf),
    .in_adc_h (tbus.adc_h),
    .coef_h   (hc_r),
    .out_hum  (hum)
  );

  always_ff @(posedge clk) begin
    tdl_r[0] <= tbus.temp;
    for (int i = 1; i < PL; i++) begin
      tdl_r[i] <= tdl_r[i-1];
    end
    hdl_r[0] <= hum;
    for (int i = 1; i < HD; i++) begin
      hdl_r[i] <= hdl_r[i-1];
    end
  end

  assign out_valid                = p_valid;
  assign out_temperature_centideg = tdl_r[PL-1];
  assign out_pressure_pascal      = p_pa;
  assign out_pressure_invalid     = p_inv;
  assign out_humidity_q22_10      = hdl_r[HD-1];

`ifndef ASSERT_OFF
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_invalid |-> out_pressure_pascal == 32'd0)
    else $error("invalid pressure not zero");
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q22_10 <= pthc_pkg::HUM_MAX)
    else $error("humidity out of range");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, pthc_pkg::TOTAL_LAT))
    else $error("result without transaction");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer pressure, humidity and temperature
// compensation block. A directed table runs first, then random readings
// under several coefficient sets; every result strobe is compared field by
// field against an in-bench model of the compensation formulas.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM  = 850;
  localparam int MAX_CYC   = 400000;
  localparam int N_SETS    = 6;

  typedef struct {
    logic [19:0] rp;
    logic [19:0] rt;
    logic [15:0] rh;
    logic        has_known;
    logic [31:0] k_temp;
    logic [31:0] k_press;
    logic        k_inv;
    logic [16:0] k_hum;
  } reading_row_t;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic        inv;
    logic [16:0] hum;
  } comp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [19:0] in_raw_pressure = '0;
  logic [19:0] in_raw_temperature = '0;
  logic [15:0] in_raw_humidity = '0;
  logic        out_valid;
  logic [31:0] out_temperature_centideg;
  logic [31:0] out_pressure_pascal;
  logic        out_pressure_invalid;
  logic [16:0] out_humidity_q22_10;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [47:0] c_temp;
  logic [63:0] c_plow, c_phigh, c_hum;
  logic [15:0] c_p9;

  comp_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;

  pth_sensor_compensation_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sxt(input logic [31:0] v, input int bits);
    logic [31:0] s;
    s = 32'd1 << (bits - 1);
    v = v & ((32'd1 << bits) - 32'd1);
    return (v ^ s) - s;
  endfunction

  function automatic comp_result_t compensate(input logic [19:0] rp, input logic [19:0] rt,
                                              input logic [15:0] rh);
    comp_result_t r;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, d, tf, v1, v2, q, p, pp, x, part1, part2, s;
    t1 = {16'd0, c_temp[15:0]};
    t2 = sxt(c_temp[31:16], 16);
    t3 = sxt(c_temp[47:32], 16);
    p1 = {16'd0, c_plow[15:0]};
    p2 = sxt(c_plow[31:16], 16);
    p3 = sxt(c_plow[47:32], 16);
    p4 = sxt(c_plow[63:48], 16);
    p5 = sxt(c_phigh[15:0], 16);
    p6 = sxt(c_phigh[31:16], 16);
    p7 = sxt(c_phigh[47:32], 16);
    p8 = sxt(c_phigh[63:48], 16);
    p9 = sxt(c_p9, 16);
    h1 = {24'd0, c_hum[7:0]};
    h2 = sxt(c_hum[23:8], 16);
    h3 = {24'd0, c_hum[31:24]};
    h4 = sxt(c_hum[43:32], 12);
    h5 = sxt(c_hum[55:44], 12);
    h6 = sxt(c_hum[63:56], 8);

    a = sra(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    tf = a + b;
    r.temp = sra(tf * 32'd5 + 32'd128, 8);

    v1 = sra(tf, 1) - 32'd64000;
    q = sra(v1, 2);
    v2 = sra(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    r.inv = (v1 == 32'd0);
    if (r.inv) begin
      p = '0;
    end else begin
      p = ((32'd1048576 - {12'd0, rp}) - sra(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      pp = p >> 3;
      v1 = sra(p9 * ((pp * pp) >> 13), 12);
      v2 = sra((p >> 2) * p8, 13);
      p = p + sra(v1 + v2 + p7, 4);
    end
    r.press = p;

    x = tf - 32'd76800;
    part1 = sra((({16'd0, rh} << 14) - (h4 << 20) - (h5 * x)) + 32'd16384, 15);
    part2 = sra((sra(sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768), 10)
                 + 32'd2097152) * h2 + 32'd8192, 14);
    x = part1 * part2;
    s = sra(x, 15);
    x = x - sra(sra(s * s, 7) * h1, 4);
    if (x[31]) x = '0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:12];
    return r;
  endfunction

  task automatic write_coeff(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pthc_pkg::REG_TEMP:  c_temp = val[47:0];
      pthc_pkg::REG_PLOW:  c_plow = val;
      pthc_pkg::REG_PHIGH: c_phigh = val;
      pthc_pkg::REG_PNINE: c_p9 = val[15:0];
      pthc_pkg::REG_HUM:   c_hum = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (pthc_pkg::TOTAL_LAT + 8) @(negedge clk);
  endtask

  // drive one transaction; start stays high across back-to-back readings
  task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt,
                              input logic [15:0] rh, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_raw_pressure <= rp;
    in_raw_temperature <= rt;
    in_raw_humidity <= rh;
    do @(posedge clk); while (busy);
    pending_results.push_back(compensate(rp, rt, rh));
    @(negedge clk);
  endtask

  task automatic load_set(input int k);
    logic [63:0] tv, plv, phv, hv, p9v;
    case (k)
      0: begin
        tv = {16'd50, 16'd26435, 16'd27504};
        plv = {16'd2855, 16'hD7D3, 16'h0BD0, 16'd36477};
        phv = {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140};
        p9v = 64'd4285;
        hv = {8'd30, 12'd50, 12'd330, 8'd0, 16'd360, 8'd75};
      end
      1: begin
        tv = 64'hFFFF_FFFF_FFFF;
        plv = '1;
        phv = '1;
        p9v = 64'hFFFF;
        hv = '1;
      end
      2: begin
        tv = {16'h7FFF, 16'h7FFF, 16'hFFFF};
        plv = {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        phv = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        p9v = 64'h8000;
        hv = {8'h7F, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 8'hFF};
      end
      3: begin
        tv = {16'h8000, 16'h8000, 16'h0000};
        plv = {16'h8000, 16'h7FFF, 16'h8000, 16'h0001};
        phv = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
        p9v = 64'h7FFF;
        hv = {8'h80, 12'h800, 12'h7FF, 8'h00, 16'h8000, 8'h00};
      end
      default: begin
        tv = {$urandom, $urandom};
        plv = {$urandom, $urandom};
        phv = {$urandom, $urandom};
        p9v = {$urandom, $urandom};
        hv = {$urandom, $urandom};
        if ($urandom_range(0, 1)) plv[15:0] = 16'($urandom_range(20000, 40000));
      end
    endcase
    write_coeff(pthc_pkg::REG_TEMP, tv);
    write_coeff(pthc_pkg::REG_PLOW, plv);
    write_coeff(pthc_pkg::REG_PHIGH, phv);
    write_coeff(pthc_pkg::REG_PNINE, p9v);
    write_coeff(pthc_pkg::REG_HUM, hv);
  endtask

  always @(posedge clk) begin
    comp_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no reading outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_temperature_centideg !== e.temp) begin
          $error("temperature_centideg exp %0d got %0d", $signed(e.temp),
                 $signed(out_temperature_centideg));
          errors++;
        end
        if (out_pressure_pascal !== e.press) begin
          $error("pressure_pascal exp %0d got %0d", e.press, out_pressure_pascal);
          errors++;
        end
        if (out_pressure_invalid !== e.inv) begin
          $error("pressure_invalid exp %0b got %0b", e.inv, out_pressure_invalid);
          errors++;
        end
        if (out_humidity_q22_10 !== e.hum) begin
          $error("humidity_q22_10 exp %0d got %0d", e.hum, out_humidity_q22_10);
          errors++;
        end
      end
    end
  end

  reading_row_t directed[] = '{
    // all coefficients zero: divisor is zero, everything else zero
    '{20'd0, 20'd0, 16'd0, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0},
    '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0},
    '{20'h55555, 20'hAAAAA, 16'h5555, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0},
    '{20'hAAAAA, 20'h55555, 16'hAAAA, 1'b1, 32'd0, 32'd0, 1'b1, 17'd0},
    // rows checked by the predictor under typical coefficients
    '{20'd415148, 20'd519888, 16'd30000, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'd0, 20'd0, 16'd0, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'd300000, 20'd400000, 16'd0, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'd500000, 20'd600000, 16'hFFFF, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'h80000, 20'h80000, 16'h8000, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0},
    '{20'h00001, 20'h00001, 16'h0001, 1'b0, 32'd0, 32'd0, 1'b0, 17'd0}
  };

  initial begin
    comp_result_t got;
    c_temp = '0; c_plow = '0; c_phigh = '0; c_p9 = '0; c_hum = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (i == 4) begin
        start <= 1'b0;
        drain_results();
        load_set(0);
      end
      if (directed[i].has_known) begin
        got = compensate(directed[i].rp, directed[i].rt, directed[i].rh);
        if (got.temp !== directed[i].k_temp || got.press !== directed[i].k_press ||
            got.inv !== directed[i].k_inv || got.hum !== directed[i].k_hum) begin
          $error("predictor disagrees with directed row %0d", i);
          errors++;
        end
      end
      send_reading(directed[i].rp, directed[i].rt, directed[i].rh, 0);
    end

    for (int set = 0; set < N_SETS; set++) begin
      start <= 1'b0;
      drain_results();
      load_set(set == 0 ? 0 : set);
      for (int n = 0; n < N_RANDOM / N_SETS; n++) begin
        logic [19:0] rp, rt;
        logic [15:0] rh;
        int gap;
        rp = 20'($urandom);
        rt = 20'($urandom);
        rh = 16'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          rt = 20'($urandom_range(380000, 640000));
          rp = 20'($urandom_range(250000, 600000));
        end
        gap = (n % 100 < 40) ? 0 : $urandom_range(0, 19);
        send_reading(rp, rt, rh, gap);
        if (n == 60) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
    end

    start <= 1'b0;
    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pthc_pkg.sv
rtl/core/pthc_temp.sv
rtl/core/pthc_div.sv
rtl/core/pthc_press.sv
rtl/core/pthc_hum.sv
rtl/core/pth_sensor_compensation_top.sv
tb/tb_top.sv
